>>> src/candidate_pool_pop_best_defines.svh
// Assertion macros shared by the candidate pool RTL.
// No dependencies; each macro expects i_clk and i_rst_n in the including scope.
`ifndef CANDIDATE_POOL_POP_BEST_DEFINES_SVH
`define CANDIDATE_POOL_POP_BEST_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define CPP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked on every clock edge outside reset.
`define CPP_ASSERT_ALW(lbl, cond, msg) \
    `CPP_ASSERT_IMP(lbl, 1'b1, cond, msg)

`endif

>>> src/cpp_pkg.sv
// Shared constants, codes and types for the candidate pool.
// No dependencies.
package cpp_pkg;

    localparam int CAPACITY    = 64;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int ID_W        = 32;
    localparam int DIST_W      = 32;
    localparam int SLOT_IN_W   = 6;
    localparam int COUNT_OUT_W = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic signed [ID_W-1:0] EMPTY_ID = '1;
    localparam logic [COUNT_OUT_W-1:0] ENTRY_COUNT_RST = 7'd64;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_POP   = 1'b1;

    localparam logic ORDER_MIN = 1'b0;
    localparam logic ORDER_MAX = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_POP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic              wr_live;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_slot;
        logic              clr_en;
        logic [SLOT_W-1:0] clr_slot;
    } t_store_req;

endpackage

>>> src/cpp_store.sv
// Slot storage: id and distance memories plus per-slot live flags.
// Depends on cpp_pkg.
module cpp_store (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cpp_pkg::t_store_req                i_req,
    input  logic signed [cpp_pkg::ID_W-1:0]    i_wr_id,
    input  logic signed [cpp_pkg::DIST_W-1:0]  i_wr_dist,
    input  logic [cpp_pkg::SLOT_W-1:0]         i_q_slot,
    output logic                               o_q_live,
    output logic                               o_rd_live,
    output logic signed [cpp_pkg::ID_W-1:0]    o_rd_id,
    output logic signed [cpp_pkg::DIST_W-1:0]  o_rd_dist
);
    import cpp_pkg::*;

    logic signed [ID_W-1:0]   r_id_mem   [CAPACITY];
    logic signed [DIST_W-1:0] r_dist_mem [CAPACITY];
    logic [CAPACITY-1:0]      r_live;
    logic                     r_rd_live;
    logic signed [ID_W-1:0]   r_rd_id;
    logic signed [DIST_W-1:0] r_rd_dist;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_id_mem[i_req.wr_slot]   <= i_wr_id;
            r_dist_mem[i_req.wr_slot] <= i_wr_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_id   <= r_id_mem[i_req.rd_slot];
            r_rd_dist <= r_dist_mem[i_req.rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_rd_live <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_live[i_req.wr_slot] <= i_req.wr_live;
            end
            if (i_req.clr_en) begin
                r_live[i_req.clr_slot] <= 1'b0;
            end
            if (i_req.rd_en) begin
                r_rd_live <= r_live[i_req.rd_slot];
            end
        end
    end

    assign o_q_live  = r_live[i_q_slot];
    assign o_rd_live = r_rd_live;
    assign o_rd_id   = r_rd_id;
    assign o_rd_dist = r_rd_dist;

endmodule

>>> src/cpp_best.sv
// Shared compare unit: keeps the best live entry seen during a scan.
// Depends on cpp_pkg.
module cpp_best (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clear,
    input  logic                               i_sample,
    input  logic                               i_order,
    input  logic                               i_live,
    input  logic signed [cpp_pkg::ID_W-1:0]    i_id,
    input  logic signed [cpp_pkg::DIST_W-1:0]  i_dist,
    input  logic [cpp_pkg::SLOT_W-1:0]         i_slot,
    output logic                               o_have,
    output logic signed [cpp_pkg::ID_W-1:0]    o_best_id,
    output logic signed [cpp_pkg::DIST_W-1:0]  o_best_dist,
    output logic [cpp_pkg::SLOT_W-1:0]         o_best_slot
);
    import cpp_pkg::*;

    logic                     r_have;
    logic signed [ID_W-1:0]   r_best_id;
    logic signed [DIST_W-1:0] r_best_dist;
    logic [SLOT_W-1:0]        r_best_slot;
    logic                     s_better;
    logic                     s_take;

    // ties go to the later slot
    always_comb begin
        if (i_order == ORDER_MIN) begin
            s_better = (i_dist <= r_best_dist);
        end else begin
            s_better = (i_dist >= r_best_dist);
        end
        s_take = i_sample && i_live && (!r_have || s_better);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_clear) begin
            r_have <= 1'b0;
        end else if (s_take) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take && !i_clear) begin
            r_best_id   <= i_id;
            r_best_dist <= i_dist;
            r_best_slot <= i_slot;
        end
    end

    assign o_have      = r_have;
    assign o_best_id   = r_best_id;
    assign o_best_dist = r_best_dist;
    assign o_best_slot = r_best_slot;

endmodule

>>> src/candidate_pool_pop_best.sv
// Candidate pool of CAPACITY slots, each an entry id and a signed distance.
// Input channel: i_valid / o_stall with i_mode, i_slot, i_entry_id, i_distance.
// i_mode write stores id and distance into i_slot; i_mode pop removes the best
// live entry among the first entry_count slots (smallest distance with
// order_mode 0, largest with 1, ties to the highest slot).
// Output channel: o_valid / i_stall, exactly one transaction per input
// transaction, in order, held in an output register until taken.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 order_mode,
// 1 entry_count); other indexes are ignored. Write only while idle.
// Timing: one item at a time. A write passes ST_WRITE, then ST_EMIT.
// A pop passes ST_SCAN, ST_POP and ST_EMIT; in ST_SCAN the single comparator
// walks the first min(entry_count, CAPACITY) slots, one read per cycle.
// Reset (synchronous, active low) empties all slots, clears the live count,
// sets order_mode 0 and entry_count 64; no clearing pass is needed.
// A stalled result still lets one more item in; that item holds its result
// until the output register drains, and input stalls meanwhile.
// Depends on cpp_pkg, cpp_store, cpp_best and the assertion macro header.
`include "candidate_pool_pop_best_defines.svh"

module candidate_pool_pop_best (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [cpp_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [cpp_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_mode,
    input  logic [cpp_pkg::SLOT_IN_W-1:0]          i_slot,
    input  logic signed [cpp_pkg::ID_W-1:0]        i_entry_id,
    input  logic signed [cpp_pkg::DIST_W-1:0]      i_distance,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [cpp_pkg::ID_W-1:0]        o_popped_id,
    output logic signed [cpp_pkg::DIST_W-1:0]      o_best_distance,
    output logic                                   o_found,
    output logic [cpp_pkg::COUNT_OUT_W-1:0]        o_valid_count
);
    import cpp_pkg::*;

    t_state                    r_state;
    t_state                    n_state;

    logic                      r_order_mode;
    logic [COUNT_OUT_W-1:0]    r_entry_count;
    logic [CNT_W-1:0]          r_live_cnt;
    logic [CNT_W-1:0]          r_idx;
    logic                      r_rd_pend;
    logic [SLOT_W-1:0]         r_rd_slot;

    logic                      r_mode;
    logic [SLOT_IN_W-1:0]      r_slot;
    logic signed [ID_W-1:0]    r_in_id;
    logic signed [DIST_W-1:0]  r_in_dist;

    logic signed [ID_W-1:0]    r_res_id;
    logic signed [DIST_W-1:0]  r_res_dist;
    logic                      r_res_found;

    logic                      r_out_valid;
    logic signed [ID_W-1:0]    r_out_id;
    logic signed [DIST_W-1:0]  r_out_dist;
    logic                      r_out_found;
    logic [COUNT_OUT_W-1:0]    r_out_cnt;

    logic                      s_accept;
    logic [CNT_W-1:0]          s_limit;
    logic                      s_wr_ok;
    logic                      s_new_live;
    logic                      s_out_free;
    logic                      s_emit;
    logic                      s_best_clear;
    logic                      s_out_none;
    t_store_req                s_req;

    logic                      s_q_live;
    logic                      s_rd_live;
    logic signed [ID_W-1:0]    s_rd_id;
    logic signed [DIST_W-1:0]  s_rd_dist;
    logic                      s_have;
    logic signed [ID_W-1:0]    s_best_id;
    logic signed [DIST_W-1:0]  s_best_dist;
    logic [SLOT_W-1:0]         s_best_slot;

    assign s_accept   = i_valid && !o_stall;
    assign s_limit    = (int'(r_entry_count) > CAPACITY) ? CNT_W'(CAPACITY)
                                                          : CNT_W'(r_entry_count);
    assign s_wr_ok    = (int'(r_slot) < CAPACITY);
    assign s_new_live = !r_in_id[ID_W-1];
    assign s_out_free = !r_out_valid || !i_stall;
    assign s_out_none = (o_popped_id == EMPTY_ID) && (o_best_distance == '0);

    cpp_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (s_req),
        .i_wr_id   (r_in_id),
        .i_wr_dist (r_in_dist),
        .i_q_slot  (SLOT_W'(r_slot)),
        .o_q_live  (s_q_live),
        .o_rd_live (s_rd_live),
        .o_rd_id   (s_rd_id),
        .o_rd_dist (s_rd_dist)
    );

    cpp_best u_best (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (s_best_clear),
        .i_sample    (r_rd_pend),
        .i_order     (r_order_mode),
        .i_live      (s_rd_live),
        .i_id        (s_rd_id),
        .i_dist      (s_rd_dist),
        .i_slot      (r_rd_slot),
        .o_have      (s_have),
        .o_best_id   (s_best_id),
        .o_best_dist (s_best_dist),
        .o_best_slot (s_best_slot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = (i_mode == MODE_WRITE) ? ST_WRITE : ST_SCAN;
                end
            end
            ST_WRITE: begin
                n_state = ST_EMIT;
            end
            ST_SCAN: begin
                if (r_idx >= s_limit) begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (s_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_stall      = 1'b1;
        s_emit       = 1'b0;
        s_best_clear = 1'b0;
        s_req        = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall      = 1'b0;
                s_best_clear = 1'b1;
            end
            ST_WRITE: begin
                s_req.wr_en   = s_wr_ok;
                s_req.wr_slot = SLOT_W'(r_slot);
                s_req.wr_live = s_new_live;
            end
            ST_SCAN: begin
                s_req.rd_en   = (r_idx < s_limit);
                s_req.rd_slot = SLOT_W'(r_idx);
            end
            ST_POP: begin
                s_req.clr_en   = s_have;
                s_req.clr_slot = s_best_slot;
            end
            ST_EMIT: begin
                s_emit = s_out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_order_mode  <= ORDER_MIN;
            r_entry_count <= ENTRY_COUNT_RST;
            r_live_cnt    <= '0;
            r_idx         <= '0;
            r_rd_pend     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= s_req.rd_en;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ORDER_MODE) begin
                    r_order_mode <= i_cfg_data[0];
                end else if (i_cfg_idx == REG_ENTRY_COUNT) begin
                    r_entry_count <= COUNT_OUT_W'(i_cfg_data);
                end
            end
            if (s_accept) begin
                r_idx <= '0;
            end else if (s_req.rd_en) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (r_state == ST_WRITE && s_wr_ok) begin
                if (!s_q_live && s_new_live) begin
                    r_live_cnt <= r_live_cnt + CNT_W'(1);
                end else if (s_q_live && !s_new_live && r_live_cnt != '0) begin
                    r_live_cnt <= r_live_cnt - CNT_W'(1);
                end
            end else if (r_state == ST_POP && s_have && r_live_cnt != '0) begin
                r_live_cnt <= r_live_cnt - CNT_W'(1);
            end
            if (s_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mode    <= i_mode;
            r_slot    <= i_slot;
            r_in_id   <= i_entry_id;
            r_in_dist <= i_distance;
        end
        if (s_req.rd_en) begin
            r_rd_slot <= s_req.rd_slot;
        end
        if (r_state == ST_POP && r_mode == MODE_POP && s_have) begin
            r_res_id    <= s_best_id;
            r_res_dist  <= s_best_dist;
            r_res_found <= 1'b1;
        end else if (r_state == ST_POP || r_state == ST_WRITE) begin
            r_res_id    <= EMPTY_ID;
            r_res_dist  <= '0;
            r_res_found <= 1'b0;
        end
        if (s_emit) begin
            r_out_id    <= r_res_id;
            r_out_dist  <= r_res_dist;
            r_out_found <= r_res_found;
            r_out_cnt   <= COUNT_OUT_W'(r_live_cnt);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_popped_id     = r_out_id;
    assign o_best_distance = r_out_dist;
    assign o_found         = r_out_found;
    assign o_valid_count   = r_out_cnt;

    `CPP_ASSERT_ALW(a_cnt_cap, int'(r_live_cnt) <= CAPACITY, "live count above capacity")
    `CPP_ASSERT_IMP(a_found_id, o_valid && o_found, !o_popped_id[ID_W-1], "found with empty id")
    `CPP_ASSERT_IMP(a_none_empty, o_valid && !o_found, s_out_none, "empty result not cleared")
    `CPP_ASSERT_IMP(a_scan_bound, r_state == ST_SCAN, r_idx <= s_limit, "scan index past limit")

endmodule

>>> bench/tb.sv
// Self-checking bench for candidate_pool_pop_best: writes slots, pops the best entry
// and compares every result against a behavioral mirror of the pool.
// Depends on cpp_pkg and the candidate_pool_pop_best RTL.
`timescale 1ns / 1ps

module tb;
    import cpp_pkg::*;

    localparam int LIMIT = 600000;

    typedef struct packed {
        logic signed [ID_W-1:0]   id;
        logic signed [DIST_W-1:0] dis;
        logic                     found;
        logic [COUNT_OUT_W-1:0]   count;
    } t_outcome;

    class pool_mirror;
        logic signed [ID_W-1:0]   id_copy[CAPACITY];
        logic signed [DIST_W-1:0] dis_copy[CAPACITY];
        int                       live;
        logic                     order;
        logic [CFG_DATA_W-1:0]    scan_len;
        t_outcome                 due[$];
        int                       errors;

        function new();
            foreach (id_copy[i]) begin
                id_copy[i] = EMPTY_ID;
                dis_copy[i] = '0;
            end
            live = 0;
            order = ORDER_MIN;
            scan_len = ENTRY_COUNT_RST;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_ORDER_MODE) begin
                order = val[0];
            end else if (idx == REG_ENTRY_COUNT) begin
                scan_len = val;
            end
        endfunction

        // accepted transaction: update the pool copy and queue the outcome it owes
        function void absorb(logic mode, logic [SLOT_IN_W-1:0] slot,
                             logic signed [ID_W-1:0] eid, logic signed [DIST_W-1:0] dis);
            t_outcome                 o;
            int                       span;
            int                       pick;
            bit                       have;
            logic signed [DIST_W-1:0] best;
            o.id = EMPTY_ID;
            o.dis = '0;
            o.found = 1'b0;
            if (mode == MODE_WRITE) begin
                if (id_copy[slot] < 0 && eid >= 0) begin
                    live++;
                end else if (id_copy[slot] >= 0 && eid < 0 && live > 0) begin
                    live--;
                end
                id_copy[slot] = eid;
                dis_copy[slot] = dis;
            end else begin
                span = (scan_len > CAPACITY) ? CAPACITY : int'(scan_len);
                have = 0;
                pick = 0;
                best = '0;
                for (int i = 0; i < span; i++) begin
                    if (id_copy[i] >= 0 && (!have || (order == ORDER_MAX ?
                            dis_copy[i] >= best : dis_copy[i] <= best))) begin
                        have = 1;
                        best = dis_copy[i];
                        pick = i;
                    end
                end
                if (have) begin
                    o.id = id_copy[pick];
                    o.dis = best;
                    o.found = 1'b1;
                    id_copy[pick] = EMPTY_ID;
                    if (live > 0) live--;
                end
            end
            o.count = live[COUNT_OUT_W-1:0];
            due.push_back(o);
        endfunction

        task compare(logic signed [ID_W-1:0] id, logic signed [DIST_W-1:0] dis,
                     logic found, logic [COUNT_OUT_W-1:0] count);
            t_outcome w;
            if (due.size() == 0) begin
                report($sformatf("unexpected result id %0d", id));
                return;
            end
            w = due.pop_front();
            if (id !== w.id)
                report($sformatf("popped_id %0d, want %0d", id, w.id));
            if (dis !== w.dis)
                report($sformatf("best_distance %0d, want %0d", dis, w.dis));
            if (found !== w.found)
                report($sformatf("found %0b, want %0b", found, w.found));
            if (count !== w.count)
                report($sformatf("valid_count %0d, want %0d", count, w.count));
        endtask
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic                     i_mode;
    logic [SLOT_IN_W-1:0]     i_slot;
    logic signed [ID_W-1:0]   i_entry_id;
    logic signed [DIST_W-1:0] i_distance;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [ID_W-1:0]   o_popped_id;
    logic signed [DIST_W-1:0] o_best_distance;
    logic                     o_found;
    logic [COUNT_OUT_W-1:0]   o_valid_count;

    pool_mirror pool;
    bit         calm;
    int         cycles;
    int         run_left;
    bit         stalled;

    candidate_pool_pop_best uut (.*);

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_mode = MODE_WRITE;
        i_slot = '0;
        i_entry_id = '0;
        i_distance = '0;
        i_stall = 1'b0;
        calm = 0;
        cycles = 0;
        run_left = 0;
        stalled = 0;
        pool = new();
    end

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: check on handshake, then pick the next stall level
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                pool.compare(o_popped_id, o_best_distance, o_found, o_valid_count);
            if (run_left > 0) begin
                run_left--;
            end else begin
                stalled = !calm && $urandom_range(0, 2) == 0;
                run_left = stalled ? $urandom_range(1, 19) : $urandom_range(1, 40);
            end
            i_stall <= stalled && !calm;
        end
    end

    task automatic send_item(input logic mode, input logic [SLOT_IN_W-1:0] slot,
                             input logic signed [ID_W-1:0] eid,
                             input logic signed [DIST_W-1:0] dis);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_slot <= slot;
        i_entry_id <= eid;
        i_distance <= dis;
        do @(posedge i_clk); while (o_stall);
        pool.absorb(mode, slot, eid, dis);
    endtask

    task automatic write_slot(input int slot, input logic signed [ID_W-1:0] eid,
                              input logic signed [DIST_W-1:0] dis);
        send_item(MODE_WRITE, slot[SLOT_IN_W-1:0], eid, dis);
    endtask

    task automatic pop_best();
        send_item(MODE_POP, SLOT_IN_W'($urandom()), $urandom(), $urandom());
    endtask

    // hold off the input until every outstanding result has been taken
    task automatic settle();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pool.due.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pool.write_reg(idx, val);
    endtask

    function automatic logic signed [DIST_W-1:0] pick_distance();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2, 3: return $signed($urandom_range(0, 6)) - 3;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [ID_W-1:0] pick_id();
        if ($urandom_range(0, 6) == 0) return EMPTY_ID;
        return $urandom() & 32'h7FFF_FFFF;
    endfunction

    initial begin
        logic                  orders[8];
        int                    counts[8];
        int                    span;
        int                    sent;
        int                    kind;
        int                    run;
        logic                  mode;
        logic [SLOT_IN_W-1:0]  slot;

        orders = '{ORDER_MIN, ORDER_MAX, ORDER_MIN, ORDER_MAX,
                   ORDER_MIN, ORDER_MAX, ORDER_MIN, ORDER_MAX};
        counts = '{64, 1, $urandom_range(2, 63), 64, 1, $urandom_range(2, 63),
                   $urandom_range(2, 63), 64};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // give every distance entry a defined value before any scan
        for (int s = 0; s < CAPACITY; s++)
            write_slot(s, EMPTY_ID, pick_distance());

        // directed: empty pool, count moves, extremes, ties to the highest slot
        pop_best();
        write_slot(0, 0, 32'sh8000_0000);
        write_slot(63, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        write_slot(5, 7, 0);
        write_slot(6, 8, 0);
        write_slot(5, EMPTY_ID, 5);
        write_slot(5, EMPTY_ID, 6);
        write_slot(6, 9, 0);
        write_slot(4, 3, 0);
        repeat (5) pop_best();

        write_reg(REG_ORDER_MODE, CFG_DATA_W'(ORDER_MAX));
        write_slot(10, 1, 32'sh8000_0000);
        write_slot(20, 2, 32'sh8000_0000);
        repeat (2) pop_best();

        // scan length of zero, above the pool size, and a single slot
        write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(0));
        write_slot(1, 5, 1);
        pop_best();
        write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(100));
        write_slot(62, 6, 2);
        pop_best();
        write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(1));
        pop_best();
        write_slot(0, 4, -9);
        pop_best();

        // random phases: fill runs, drain runs and mixed runs per setting
        for (int p = 0; p < 8; p++) begin
            if (p == 7) calm = 1;
            write_reg(REG_ORDER_MODE, CFG_DATA_W'(orders[p]));
            write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(counts[p]));
            span = counts[p];
            sent = 0;
            while (sent < 107) begin
                kind = $urandom_range(0, 3);
                run = $urandom_range(1, 12);
                for (int k = 0; k < run && sent < 107; k++) begin
                    case (kind)
                        0: mode = MODE_WRITE;
                        1: mode = MODE_POP;
                        default: mode = ($urandom_range(0, 9) < 4) ? MODE_POP : MODE_WRITE;
                    endcase
                    slot = ($urandom_range(0, 4) == 0) ? SLOT_IN_W'($urandom_range(0, 63))
                                                       : SLOT_IN_W'($urandom_range(0, span - 1));
                    send_item(mode, slot, pick_id(), pick_distance());
                    sent++;
                    if (p == 3 && sent == 60) settle();
                end
            end
        end

        settle();
        repeat (80) @(posedge i_clk);
        if (pool.due.size() != 0)
            pool.report($sformatf("%0d results never arrived", pool.due.size()));
        if (pool.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
